>>> design/ephd_pkg.sv
// Shared widths, register indexes and constants of the echo presence detector.
package ephd_pkg;

  // Item field widths
  localparam int unsigned TimeW   = 32;
  localparam int unsigned EchoW   = 16;
  localparam int unsigned DistW   = 17;
  localparam int unsigned CountW  = 8;
  localparam int unsigned IntvW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 17;

  // Packed stream widths, padded to whole bytes
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 24;

  // Configuration reset values
  localparam logic [DistW-1:0]  DetectRst   = 17'd2000;
  localparam logic [DistW-1:0]  ReleaseRst  = 17'd3000;
  localparam logic [CountW-1:0] ConfirmRst  = 8'd3;
  localparam logic [IntvW-1:0]  IntervalRst = 16'd200;

  // Distance conversion: floor(echo * 1715 / 1000) = floor(((echo * 343) >> 3) / 25).
  // The divide by 25 is a multiply by ceil(2^27 / 25) and a shift by 27,
  // exact for all dividends below 2^22.
  localparam int unsigned     ScaledW   = 25;
  localparam int unsigned     QuotInW   = 22;
  localparam int unsigned     RecipW    = 23;
  localparam int unsigned     RecipSh   = 27;
  localparam logic [ScaledW-1:0] SpeedMul = 25'd343;
  localparam logic [RecipW-1:0]  Recip25  = 23'd5368710;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegDetect   = 2'd0,
    RegRelease  = 2'd1,
    RegConfirm  = 2'd2,
    RegInterval = 2'd3
  } cfg_reg_e;

endpackage

>>> design/echo_presence_hysteresis_detector.sv
// Echo presence detector: interval gate, echo-to-distance conversion, debounced presence.
//
// Throughput: one item per cycle unless the result side stalls; stage 1 scales the echo,
//   stage 2 is the reciprocal multiply for the divide, stage 3 updates state into the
//   result register.
// Reset: asynchronous, active low; clears the pipeline, the detector state and
//   returns the configuration registers to their default values.
module echo_presence_hysteresis_detector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [ephd_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  logic [ephd_pkg::CfgDatW-1:0]  cfg_wdata_i,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ephd_pkg::InDataW-1:0]  s_axis_tdata,   // time_ms[31:0], echo_us[47:32]
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ephd_pkg::OutDataW-1:0] m_axis_tdata    // sampled[0], present[1],
                                                        // distance[18:2], changed[19]
);
  import ephd_pkg::*;

  // Configuration registers
  logic [DistW-1:0]  detect_q, release_q;
  logic [CountW-1:0] confirm_q;
  logic [IntvW-1:0]  interval_q;

  // Pipeline registers
  logic               s1_v_q, s2_v_q, out_v_q;
  logic [TimeW-1:0]   s1_time_q, s2_time_q;
  logic               s1_echo_ok_q, s2_echo_ok_q;
  logic [QuotInW-1:0] s1_quot_in_q;
  logic [DistW-1:0]   s2_dist_q;

  // Detector state
  logic [TimeW-1:0]  last_time_q, last_time_d;
  logic [DistW-1:0]  kept_dist_q, kept_dist_d;
  logic [CountW-1:0] near_cnt_q, near_cnt_d;
  logic [CountW-1:0] far_cnt_q, far_cnt_d;
  logic              present_q, present_d;

  // Result register
  logic out_sampled_q, out_changed_q;
  logic sampled_d, changed_d;

  // Combinational intermediates
  logic                     out_free, s2_move, s1_move, in_acc;
  logic [TimeW-1:0]         in_time;
  logic [EchoW-1:0]         in_echo;
  logic [ScaledW-1:0]       scaled;
  logic [QuotInW+RecipW-1:0] quot_prod;
  logic [TimeW-1:0]         elapsed;
  logic                     is_near, is_far;

  // Handshake: a stage moves when the one after it is empty or moving
  assign out_free      = !out_v_q || m_axis_tready;
  assign s2_move       = s2_v_q && out_free;
  assign s1_move       = s1_v_q && (!s2_v_q || out_free);
  assign s_axis_tready = !s1_v_q || !s2_v_q || out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign in_time = s_axis_tdata[TimeW-1:0];
  assign in_echo = s_axis_tdata[TimeW +: EchoW];

  // Stage 1 math: echo * 343, then drop three bits (the factor 8 of 200)
  assign scaled = {{(ScaledW-EchoW){1'b0}}, in_echo} * SpeedMul;

  // Stage 2 math: divide by 25 through the reciprocal
  assign quot_prod = {{RecipW{1'b0}}, s1_quot_in_q} * {{QuotInW{1'b0}}, Recip25};

  // Stage 3: interval gate, hysteresis and debounce
  assign elapsed = s2_time_q - last_time_q;
  assign is_near = s2_echo_ok_q && (s2_dist_q < detect_q);
  assign is_far  = !s2_echo_ok_q || (s2_dist_q > release_q);

  always_comb begin
    last_time_d = last_time_q;
    kept_dist_d = kept_dist_q;
    near_cnt_d  = near_cnt_q;
    far_cnt_d   = far_cnt_q;
    present_d   = present_q;
    sampled_d   = 1'b0;
    changed_d   = 1'b0;
    if (elapsed >= {{(TimeW-IntvW){1'b0}}, interval_q}) begin
      sampled_d   = 1'b1;
      last_time_d = s2_time_q;
      if (s2_echo_ok_q) begin
        kept_dist_d = s2_dist_q;
      end
      if (is_near) begin
        if (near_cnt_q < confirm_q) begin
          near_cnt_d = near_cnt_q + 8'd1;
        end
        far_cnt_d = '0;
      end else if (is_far) begin
        if (far_cnt_q < confirm_q) begin
          far_cnt_d = far_cnt_q + 8'd1;
        end
        near_cnt_d = '0;
      end
      if (!present_q && (near_cnt_d >= confirm_q)) begin
        present_d = 1'b1;
        changed_d = 1'b1;
      end else if (present_q && (far_cnt_d >= confirm_q)) begin
        present_d = 1'b0;
        changed_d = 1'b1;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detect_q   <= DetectRst;
      release_q  <= ReleaseRst;
      confirm_q  <= ConfirmRst;
      interval_q <= IntervalRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        RegDetect:   detect_q   <= cfg_wdata_i[DistW-1:0];
        RegRelease:  release_q  <= cfg_wdata_i[DistW-1:0];
        RegConfirm:  confirm_q  <= cfg_wdata_i[CountW-1:0];
        RegInterval: interval_q <= cfg_wdata_i[IntvW-1:0];
        default:     ;
      endcase
    end
  end

  // Pipeline valid bits and detector state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_v_q     <= 1'b0;
      last_time_q <= '0;
      kept_dist_q <= '0;
      near_cnt_q  <= '0;
      far_cnt_q   <= '0;
      present_q   <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_move) begin
        s1_v_q <= 1'b0;
      end
      if (s1_move) begin
        s2_v_q <= 1'b1;
      end else if (s2_move) begin
        s2_v_q <= 1'b0;
      end
      if (s2_move) begin
        out_v_q     <= 1'b1;
        last_time_q <= last_time_d;
        kept_dist_q <= kept_dist_d;
        near_cnt_q  <= near_cnt_d;
        far_cnt_q   <= far_cnt_d;
        present_q   <= present_d;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_time_q    <= in_time;
      s1_echo_ok_q <= (in_echo != '0);
      s1_quot_in_q <= scaled[ScaledW-1:3];
    end
    if (s1_move) begin
      s2_time_q    <= s1_time_q;
      s2_echo_ok_q <= s1_echo_ok_q;
      s2_dist_q    <= quot_prod[RecipSh +: DistW];
    end
    if (s2_move) begin
      out_sampled_q <= sampled_d;
      out_changed_q <= changed_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(OutDataW-DistW-3){1'b0}}, out_changed_q, kept_dist_q,
                          present_q, out_sampled_q};

endmodule

>>> design/ephd_checker.sv
// Port-level checks for the echo presence detector, bound to the top level.
module ephd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ephd_pkg::OutDataW-1:0] m_axis_tdata
);
  import ephd_pkg::*;

  logic             out_acc;
  logic             res_sampled, res_present, res_changed;
  logic [DistW-1:0] res_dist;
  logic             prev_present_q;
  logic [DistW-1:0] prev_dist_q;

  assign out_acc     = m_axis_tvalid && m_axis_tready;
  assign res_sampled = m_axis_tdata[0];
  assign res_present = m_axis_tdata[1];
  assign res_dist    = m_axis_tdata[2 +: DistW];
  assign res_changed = m_axis_tdata[DistW+2];

  // Presence and distance as of the last delivered item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_present_q <= 1'b0;
      prev_dist_q    <= '0;
    end else if (out_acc) begin
      prev_present_q <= res_present;
      prev_dist_q    <= res_dist;
    end
  end

  // The changed flag is exactly a flip of presence between delivered items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> ((res_present ^ prev_present_q) == res_changed))
    else $error("changed flag disagrees with presence history");

  // A gated-out item leaves presence and distance untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !res_sampled) |-> (!res_changed && (res_dist == prev_dist_q)))
    else $error("unsampled item altered the result state");

  // A result waiting on the sink holds its data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result item dropped or changed");

  // Input side keeps accepting when the result side is draining freely
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid && $past(!m_axis_tvalid) && $past(!s_axis_tvalid, 2)) |-> s_axis_tready)
    else $error("input stalled with an empty pipeline");

endmodule

bind echo_presence_hysteresis_detector ephd_checker u_ephd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> dv/echo_presence_hysteresis_detector_tb.sv
// Self-checking testbench of the echo presence detector: directed rows, then random phases.
module echo_presence_hysteresis_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ephd_pkg::*;

  // Result item as packed on m_axis_tdata, lowest field last
  typedef struct packed {
    logic             changed;
    logic [DistW-1:0] distance;
    logic             present;
    logic             sampled;
  } presence_result_t;

  // One directed row; expected fields are used only when chk is set
  typedef struct packed {
    logic [TimeW-1:0] t;
    logic [EchoW-1:0] e;
    logic             chk;
    logic             s;
    logic             p;
    logic [DistW-1:0] d;
    logic             c;
  } stim_row_t;

  typedef enum int {KindNear, KindFar, KindBetween, KindTimeout, KindAny} echo_kind_e;

  localparam int unsigned NumDirected = 16;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_addr_i;
  logic [CfgDatW-1:0]  cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  // Predictor copy of configuration and detector state
  logic [DistW-1:0]  cfg_detect;
  logic [DistW-1:0]  cfg_release;
  logic [CountW-1:0] cfg_confirm;
  logic [IntvW-1:0]  cfg_interval;
  logic [TimeW-1:0]  last_seen_ms;
  logic [DistW-1:0]  held_dist;
  logic [CountW-1:0] near_cnt;
  logic [CountW-1:0] far_cnt;
  logic              present_q;

  presence_result_t pending_presence[$];
  int unsigned      mismatches;
  logic             gaps_en;
  logic             stall_en;
  logic [TimeW-1:0] clock_ms;
  echo_kind_e       run_kind;
  int unsigned      run_left;

  // Directed rows under reset configuration (detect 2000, release 3000, confirm 3, gap 200)
  stim_row_t directed_rows [0:NumDirected-1] = '{
    '{32'd0,          16'd1000,  1'b1, 1'b0, 1'b0, 17'd0,      1'b0}, // before first gap
    '{32'd199,        16'd1000,  1'b1, 1'b0, 1'b0, 17'd0,      1'b0}, // one ms short
    '{32'd200,        16'd1000,  1'b1, 1'b1, 1'b0, 17'd1715,   1'b0}, // first sample, near
    '{32'd400,        16'd1000,  1'b0, 1'b0, 1'b0, 17'd0,      1'b0},
    '{32'd600,        16'd1000,  1'b0, 1'b0, 1'b0, 17'd0,      1'b0}, // presence sets
    '{32'd700,        16'd0,     1'b0, 1'b0, 1'b0, 17'd0,      1'b0}, // gated out
    '{32'd800,        16'd0,     1'b1, 1'b1, 1'b1, 17'd1715,   1'b0}, // timeout keeps distance
    '{32'd1000,       16'd1,     1'b0, 1'b0, 1'b0, 17'd0,      1'b0}, // smallest echo
    '{32'd1200,       16'hFFFF,  1'b1, 1'b1, 1'b1, 17'd112392, 1'b0}, // largest echo
    '{32'd1400,       16'd1749,  1'b0, 1'b0, 1'b0, 17'd0,      1'b0}, // just inside band
    '{32'd1600,       16'd1750,  1'b0, 1'b0, 1'b0, 17'd0,      1'b0}, // just above release
    '{32'd1800,       16'hFFFF,  1'b1, 1'b1, 1'b0, 17'd112392, 1'b1}, // presence clears
    '{32'hFFFF_FFFF,  16'd1166,  1'b0, 1'b0, 1'b0, 17'd0,      1'b0}, // top of time range
    '{32'h0000_0050,  16'd1166,  1'b0, 1'b0, 1'b0, 17'd0,      1'b0}, // wrapped, gated out
    '{32'h0000_00C7,  16'd1167,  1'b0, 1'b0, 1'b0, 17'd0,      1'b0}, // wrapped, exact gap
    '{32'h8000_0000,  16'h8000,  1'b0, 1'b0, 1'b0, 17'd0,      1'b0}
  };

  echo_presence_hysteresis_detector i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Interval gate, distance conversion, debounce counters and presence flag
  function automatic presence_result_t predict_presence(input logic [TimeW-1:0] now,
                                                        input logic [EchoW-1:0] echo);
    presence_result_t res;
    logic [TimeW-1:0] since;
    int unsigned      conv_dist;
    logic             valid;
    res = '0;
    since = now - last_seen_ms;
    if (since >= TimeW'(cfg_interval)) begin
      valid = (echo != '0);
      conv_dist = (int'(echo) * 1715) / 1000;
      res.sampled = 1'b1;
      last_seen_ms = now;
      if (valid) held_dist = DistW'(conv_dist);
      if (valid && conv_dist < int'(cfg_detect)) begin
        if (near_cnt < cfg_confirm) near_cnt = near_cnt + 1'b1;
        far_cnt = '0;
      end else if (!valid || conv_dist > int'(cfg_release)) begin
        if (far_cnt < cfg_confirm) far_cnt = far_cnt + 1'b1;
        near_cnt = '0;
      end
      if (!present_q && near_cnt >= cfg_confirm) begin
        present_q = 1'b1;
        res.changed = 1'b1;
      end else if (present_q && far_cnt >= cfg_confirm) begin
        present_q = 1'b0;
        res.changed = 1'b1;
      end
    end
    res.present = present_q;
    res.distance = held_dist;
    return res;
  endfunction

  // Echo whose distance does not exceed the given one, clamped to the field
  function automatic logic [EchoW-1:0] echo_for_dist(input logic [DistW-1:0] target);
    longint unsigned e;
    e = (longint'(target) * 1000) / 1715;
    if (e > 65535) e = 65535;
    return e[EchoW-1:0];
  endfunction

  // Drive one item, optionally after random idle cycles; predict once accepted
  task automatic send_item(input logic [TimeW-1:0] t, input logic [EchoW-1:0] e,
                           input logic chk, input presence_result_t typed);
    presence_result_t res;
    while (gaps_en && $urandom_range(99) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {e, t};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    res = predict_presence(t, e);
    pending_presence.push_back(chk ? typed : res);
  endtask

  // Stop the input stream and wait until every result is out
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_presence.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Register write while idle
  task automatic write_cfg(input cfg_reg_e idx, input logic [CfgDatW-1:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      RegDetect:   cfg_detect   = val;
      RegRelease:  cfg_release  = val;
      RegConfirm:  cfg_confirm  = val[CountW-1:0];
      RegInterval: cfg_interval = val[IntvW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CfgDatW-1:0] det, input logic [CfgDatW-1:0] rel,
                            input logic [CfgDatW-1:0] conf, input logic [CfgDatW-1:0] gap);
    write_cfg(RegDetect, det);
    write_cfg(RegRelease, rel);
    write_cfg(RegConfirm, conf);
    write_cfg(RegInterval, gap);
  endtask

  // Random items: mostly on-schedule samples in runs of one kind, some noise
  task automatic run_random(input int unsigned n);
    logic [EchoW-1:0] e;
    logic [EchoW-1:0] lo;
    logic [EchoW-1:0] hi;
    int unsigned      r;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 70) clock_ms = clock_ms + cfg_interval + $urandom_range(0, 40);
      else if (r < 90) clock_ms = clock_ms + $urandom_range(0, cfg_interval);
      else clock_ms = clock_ms + $urandom;
      if (run_left == 0) begin
        r = $urandom_range(99);
        if (r < 30) run_kind = KindNear;
        else if (r < 60) run_kind = KindFar;
        else if (r < 70) run_kind = KindBetween;
        else if (r < 85) run_kind = KindTimeout;
        else run_kind = KindAny;
        run_left = $urandom_range(1, int'(cfg_confirm) + 3);
      end
      run_left--;
      case (run_kind)
        KindNear: begin
          hi = echo_for_dist(cfg_detect);
          e = EchoW'($urandom_range(1, (hi == 0) ? 1 : hi));
        end
        KindFar: begin
          lo = echo_for_dist(cfg_release);
          e = EchoW'($urandom_range((lo == 16'hFFFF) ? lo : lo + 1, 65535));
        end
        KindBetween: begin
          lo = echo_for_dist(cfg_detect);
          hi = echo_for_dist(cfg_release);
          e = EchoW'($urandom_range(lo, (hi == 16'hFFFF) ? hi : hi + 1));
        end
        KindTimeout: e = '0;
        default: e = EchoW'($urandom_range(0, 65535));
      endcase
      send_item(clock_ms, e, 1'b0, '0);
    end
  endtask

  // Receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready <= !stall_en || ($urandom_range(99) >= 14);
  end

  // Compare each result item with the oldest prediction
  always @(posedge clk_i) begin : check_result
    presence_result_t want;
    presence_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(presence_result_t)-1:0];
      if (pending_presence.size() == 0) begin
        $error("result item with no prediction waiting: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_presence.pop_front();
        if (got.sampled !== want.sampled) begin
          $error("sampled: expected %0d, actual %0d", want.sampled, got.sampled);
          mismatches++;
        end
        if (got.present !== want.present) begin
          $error("present: expected %0d, actual %0d", want.present, got.present);
          mismatches++;
        end
        if (got.distance !== want.distance) begin
          $error("distance: expected %0d, actual %0d", want.distance, got.distance);
          mismatches++;
        end
        if (got.changed !== want.changed) begin
          $error("changed: expected %0d, actual %0d", want.changed, got.changed);
          mismatches++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    presence_result_t typed;
    int unsigned      waited;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = RegDetect;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    mismatches    = 0;
    gaps_en       = 1'b1;
    stall_en      = 1'b1;
    run_left      = 0;
    run_kind      = KindAny;
    cfg_detect    = DetectRst;
    cfg_release   = ReleaseRst;
    cfg_confirm   = ConfirmRst;
    cfg_interval  = IntervalRst;
    last_seen_ms  = '0;
    held_dist     = '0;
    near_cnt      = '0;
    far_cnt       = '0;
    present_q     = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under reset configuration
    for (int i = 0; i < NumDirected; i++) begin
      typed.sampled  = directed_rows[i].s;
      typed.present  = directed_rows[i].p;
      typed.distance = directed_rows[i].d;
      typed.changed  = directed_rows[i].c;
      send_item(directed_rows[i].t, directed_rows[i].e, directed_rows[i].chk, typed);
    end
    clock_ms = 32'h8000_0000;

    // Reset configuration
    run_random(120);

    // Nothing counts as near; confirm on one sample; no gating; junk above register width
    set_config(17'd0, 17'h1FFFF, {9'($urandom), 8'd1}, {1'b1, 16'd0});
    run_random(100);

    // Detect above release: near wins; widest gate
    set_config(17'h1FFFF, 17'd0, 17'd2, 17'd65535);
    run_random(100);

    // Confirm of zero: presence toggles on every sample
    set_config(17'd5000, 17'd6000, 17'd0, 17'd0);
    run_random(80);

    // Longest confirm, equal thresholds, no idling on either side
    gaps_en  = 1'b0;
    stall_en = 1'b0;
    set_config(17'd60000, 17'd60000, 17'd255, 17'd0);
    run_random(300);
    gaps_en  = 1'b1;
    stall_en = 1'b1;

    // Random settings
    for (int p = 0; p < 3; p++) begin
      set_config(CfgDatW'($urandom), CfgDatW'($urandom), CfgDatW'($urandom_range(1, 8)),
                 CfgDatW'($urandom_range(0, 400)));
      run_random(110);
    end

    // Let the pipeline empty, then a few more cycles
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending_presence.size() != 0 && waited < 10000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_presence.size() != 0) begin
      $error("%0d predicted result items never arrived", pending_presence.size());
      mismatches++;
    end
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
